>>> rtl/assert_macros.svh
// Assertion helpers used by the deque unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DQ_ASSERT_IMP(lbl, ante, cons)
`define DQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/dq_pkg.sv
package dq_pkg;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_DUMP_FWD   = 3'd4;
  localparam logic [2:0] ACT_DUMP_BWD   = 3'd5;
  localparam logic [2:0] ACT_COUNT      = 3'd6;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic {
    FSM_RUN,
    FSM_DUMP
  } fsm_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT_RIGHT,
    OP_SHIFT_LEFT,
    OP_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     at_end;
    logic     at_slot;
  } cell_ctl_t;

endpackage

>>> rtl/double_ended_queue_unit.sv
// Channel  Signals                                               Direction
// request  in_valid, in_ready, action, value                     in
// result   out_valid, out_ready, status, item, occupancy, last   out
//
// Push, pop and count each return one result; with the result taken at once a new
// request is accepted every cycle. A dump sends one result per stored entry, since
// the cell chain rotates one position per cycle while results are taken; no request
// is accepted during it. Reset clears state, count and out_valid, not the cells.
// A stalled result holds the request side until the output register frees up.
module double_ended_queue_unit #(
  parameter int CAPACITY  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] item,
  output logic [5:0]         occupancy,
  output logic               last
);
  import dq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_BITS-1:0] cell_q [CAPACITY];
  cell_ctl_t            ctl [CAPACITY];
  logic [DATA_BITS-1:0] tap;
  logic [DATA_BITS-1:0] head_in;
  logic [DATA_BITS-1:0] push_val;

  fsm_t          state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] remain, remain_next;
  logic [CW-1:0] count_m1;
  logic          dump_fwd, dump_fwd_next;
  cell_op_t      op;

  logic          accept, out_free, load_out;
  logic          full_push;
  logic [1:0]    o_status;
  logic [31:0]   o_item;
  logic          o_last;

  function automatic logic [31:0] to_item(input logic [DATA_BITS-1:0] d);
    logic signed [DATA_BITS-1:0] s;
    s = d;
    return 32'(s);
  endfunction

  assign push_val = DATA_BITS'(value);
  assign count_m1 = count - CW'(1);
  // Cell zero takes the request value on a front push and the back entry on a
  // backward dump rotation.
  assign head_in  = (state == FSM_RUN) ? push_val : tap;

  always_comb begin
    tap = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap = tap | (cell_q[i] & {DATA_BITS{ctl[i].at_end}});
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctl[i] = {op, (count_m1 == CW'(i)), (count == CW'(i))};

    dq_cell #(
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .left_in  ((i == 0) ? head_in : cell_q[(i + CAPACITY - 1) % CAPACITY]),
      .right_in (cell_q[(i + 1) % CAPACITY]),
      .wrap_in  (cell_q[0]),
      .push_in  (push_val),
      .data     (cell_q[i])
    );
  end

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == FSM_RUN) && out_free;
  assign accept    = in_valid && in_ready;
  assign full_push = accept && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK) &&
                     (count == CW'(CAPACITY));

  always_comb begin
    state_next    = state;
    count_next    = count;
    remain_next   = remain;
    dump_fwd_next = dump_fwd;
    op            = OP_HOLD;
    load_out      = 1'b0;
    o_status      = STAT_OK;
    o_item        = '0;
    o_last        = 1'b1;
    unique case (state)
      FSM_RUN: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              if (count == CW'(CAPACITY)) begin
                o_status = STAT_FULL;
              end else begin
                op         = (action == ACT_PUSH_FRONT) ? OP_SHIFT_RIGHT : OP_LOAD;
                count_next = count + CW'(1);
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (count == '0) begin
                o_status = STAT_EMPTY;
              end else begin
                o_item     = (action == ACT_POP_FRONT) ? to_item(cell_q[0]) : to_item(tap);
                op         = (action == ACT_POP_FRONT) ? OP_SHIFT_LEFT : OP_HOLD;
                count_next = count_m1;
              end
            end
            ACT_DUMP_FWD, ACT_DUMP_BWD: begin
              if (count == '0) begin
                o_status = STAT_EMPTY;
              end else begin
                load_out      = 1'b0;
                state_next    = FSM_DUMP;
                remain_next   = count;
                dump_fwd_next = (action == ACT_DUMP_FWD);
              end
            end
            default: begin
              o_status = STAT_OK;
            end
          endcase
        end
      end
      FSM_DUMP: begin
        // Each step sends one entry and rotates the ring; after a full lap the
        // cells are back in their original order.
        if (out_free) begin
          load_out    = 1'b1;
          o_item      = dump_fwd ? to_item(cell_q[0]) : to_item(tap);
          op          = dump_fwd ? OP_SHIFT_LEFT : OP_SHIFT_RIGHT;
          remain_next = remain - CW'(1);
          o_last      = (remain == CW'(1));
          if (o_last) begin
            state_next = FSM_RUN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_RUN;
      count     <= '0;
      remain    <= '0;
      dump_fwd  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      remain   <= remain_next;
      dump_fwd <= dump_fwd_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status    <= o_status;
      item      <= o_item;
      occupancy <= 6'(count_next);
      last      <= o_last;
    end
  end

`include "assert_macros.svh"

  `DQ_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(CAPACITY))
  `DQ_ASSERT_IMP(a_dump_remain, state == FSM_DUMP, remain != '0 && remain <= count)
  `DQ_ASSERT_NEXT(a_full_push_drops, full_push, count == $past(count))
  `DQ_ASSERT_NEXT(a_dump_keeps_count, state == FSM_DUMP, count == $past(count))
  `DQ_ASSERT_IMP(a_no_accept_in_dump, state == FSM_DUMP, !accept)

endmodule

>>> rtl/dq_cell.sv
module dq_cell #(
  parameter int DATA_BITS = 32
) (
  input  logic                  clk,
  input  dq_pkg::cell_ctl_t     ctl,
  input  logic [DATA_BITS-1:0]  left_in,
  input  logic [DATA_BITS-1:0]  right_in,
  input  logic [DATA_BITS-1:0]  wrap_in,
  input  logic [DATA_BITS-1:0]  push_in,
  output logic [DATA_BITS-1:0]  data
);
  import dq_pkg::*;

  // A left shift closes the ring: the cell holding the back entry takes the front one.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_HOLD: begin
        data <= data;
      end
      OP_SHIFT_RIGHT: begin
        data <= left_in;
      end
      OP_SHIFT_LEFT: begin
        data <= ctl.at_end ? wrap_in : right_in;
      end
      OP_LOAD: begin
        if (ctl.at_slot) begin
          data <= push_in;
        end
      end
    endcase
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  localparam int DEPTH = 32;
  localparam int WIDTH = 32;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int REPORT_LIMIT = 10;

  // Not named in the package; the block treats it like a count.
  localparam logic [2:0] ACT_SPARE = 3'd7;

  typedef enum int {
    PACE_BURST,
    PACE_SPARSE,
    PACE_MIXED
  } pace_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item;
    logic [5:0]         occupancy;
    logic               last;
  } deque_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         action = ACT_COUNT;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] item;
  logic [5:0]         occupancy;
  logic               last;

  // Shadow copy of the deque contents, kept in step with accepted requests.
  logic signed [31:0] shadow_ring [DEPTH];
  int                 shadow_head = 0;
  int                 shadow_held = 0;

  deque_result_t      expected_results [$];
  int                 mismatch_count = 0;
  pace_t              pace = PACE_MIXED;

  double_ended_queue_unit #(
    .CAPACITY (DEPTH),
    .DATA_BITS(WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .item     (item),
    .occupancy(occupancy),
    .last     (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_gap();
    case (pace)
      PACE_BURST:  return 0;
      PACE_SPARSE: return $urandom_range(0, 19);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic deque_result_t make_result(logic [1:0] st, logic signed [31:0] val,
                                                 logic is_last);
    deque_result_t r;
    r.status    = st;
    r.item      = val;
    r.occupancy = 6'(shadow_held);
    r.last      = is_last;
    return r;
  endfunction

  // Updates the shadow deque for one accepted request and queues its results.
  task automatic predict_deque(input logic [2:0] act, input logic signed [31:0] val);
    int pos;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_held >= DEPTH) begin
          expected_results.push_back(make_result(STAT_FULL, '0, 1'b1));
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_ring[shadow_head] = val;
          end else begin
            shadow_ring[(shadow_head + shadow_held) % DEPTH] = val;
          end
          shadow_held++;
          expected_results.push_back(make_result(STAT_OK, '0, 1'b1));
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (shadow_held == 0) begin
          expected_results.push_back(make_result(STAT_EMPTY, '0, 1'b1));
        end else begin
          if (act == ACT_POP_FRONT) begin
            pos = shadow_head;
            shadow_head = (shadow_head + 1) % DEPTH;
          end else begin
            pos = (shadow_head + shadow_held - 1) % DEPTH;
          end
          shadow_held--;
          expected_results.push_back(make_result(STAT_OK, shadow_ring[pos], 1'b1));
        end
      end
      ACT_DUMP_FWD, ACT_DUMP_BWD: begin
        if (shadow_held == 0) begin
          expected_results.push_back(make_result(STAT_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_held; i++) begin
            pos = (act == ACT_DUMP_FWD) ? i : shadow_held - 1 - i;
            expected_results.push_back(make_result(STAT_OK,
                shadow_ring[(shadow_head + pos) % DEPTH], i + 1 == shadow_held));
          end
        end
      end
      default: begin
        expected_results.push_back(make_result(STAT_OK, '0, 1'b1));
      end
    endcase
  endtask

  // Presents one request after a drawn gap and holds it until it is taken.
  task automatic send_request(input logic [2:0] act, input logic signed [31:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_deque(act, val);
  endtask

  task automatic send_any(input logic [2:0] act);
    send_request(act, draw_value());
  endtask

  task automatic note_mismatch(input deque_result_t want, input deque_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("result mismatch: expected status %0d item %0d occupancy %0d last %0d,",
               want.status, want.item, want.occupancy, want.last,
               " got status %0d item %0d occupancy %0d last %0d",
               got.status, got.item, got.occupancy, got.last);
  endtask

  // Result side: a drawn stall before each result, then ready until one is taken.
  initial begin : result_sink
    int stall;
    @(posedge clk iff !rst);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, item, occupancy, last};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: status %0d item %0d occupancy %0d last %0d",
                   status, item, occupancy, last);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.item !== want.item ||
            got.occupancy !== want.occupancy || got.last !== want.last)
          note_mismatch(want, got);
      end
    end
  end

  // Every non-push action on an empty deque, including the spare code.
  task automatic test_empty_deque();
    pace = PACE_MIXED;
    send_any(ACT_POP_FRONT);
    send_any(ACT_POP_BACK);
    send_any(ACT_DUMP_FWD);
    send_any(ACT_DUMP_BWD);
    send_any(ACT_COUNT);
    send_any(ACT_SPARE);
  endtask

  // Extreme values through both ends, then every read-out path.
  task automatic test_extreme_values();
    pace = PACE_BURST;
    send_request(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_request(ACT_PUSH_BACK, 32'sh7fff_ffff);
    send_request(ACT_PUSH_FRONT, -32'sd1);
    send_request(ACT_PUSH_BACK, '0);
    send_request(ACT_PUSH_BACK, 32'sh5555_aaaa);
    send_any(ACT_DUMP_FWD);
    send_any(ACT_DUMP_BWD);
    send_any(ACT_COUNT);
    send_any(ACT_SPARE);
    send_any(ACT_POP_FRONT);
    send_any(ACT_POP_BACK);
    send_any(ACT_POP_FRONT);
    send_any(ACT_POP_BACK);
    send_any(ACT_POP_FRONT);
    send_any(ACT_POP_FRONT);
  endtask

  // Fill to capacity, push past it, dump the full deque and drain it past empty.
  task automatic test_fill_and_drain();
    pace = PACE_BURST;
    for (int i = 0; i < DEPTH + 2; i++)
      send_any($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK);
    pace = PACE_MIXED;
    send_any(ACT_DUMP_FWD);
    send_any(ACT_DUMP_BWD);
    send_any(ACT_COUNT);
    pace = PACE_SPARSE;
    for (int i = 0; i < DEPTH + 2; i++)
      send_any($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK);
  endtask

  // Alternating growth and shrink phases so that full and empty are both reached.
  task automatic test_random_mix();
    int roll;
    logic [2:0] act;
    for (int seg = 0; seg < 9; seg++) begin
      pace = pace_t'(seg % 3);
      for (int i = 0; i < 48; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8)
          act = $urandom_range(0, 1) ? ACT_DUMP_FWD : ACT_DUMP_BWD;
        else if (roll < 12)
          act = $urandom_range(0, 3) == 0 ? ACT_SPARE : ACT_COUNT;
        else if ((roll < 80) == (seg % 2 == 0))
          act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else
          act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
        send_any(act);
      end
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_deque();
    test_extreme_values();
    test_fill_and_drain();
    test_random_mix();
    wait_for_results();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
